>>> sv/tpls_pkg.sv
`default_nettype none

package tpls_pkg;

  localparam int unsigned FRAC_BITS_DEF = 12;
  localparam int unsigned IN_W          = 16;
  localparam int unsigned OUT_FRAC      = 12;
  localparam int unsigned OUT_ONE       = 4096;
  localparam int unsigned OUT_W         = 13;
  localparam int unsigned SQ_W          = 31;
  localparam int unsigned LEN2_W        = 32;
  localparam int unsigned DOT_W         = 33;
  localparam int unsigned MAG_W         = 32;
  localparam int unsigned ROOT_W        = 16;
  localparam int unsigned CM_QW         = 14;
  localparam int unsigned CM_W          = 13;
  localparam int unsigned COLOR_W       = 12;
  localparam int unsigned PC_W          = COLOR_W + CM_W;
  localparam int unsigned NUM_LIGHTS    = 3;
  localparam int unsigned NUM_CH        = 3;

  localparam logic [COLOR_W-1:0] LIGHT_COLOR [NUM_LIGHTS][NUM_CH] = '{
    '{12'd2867, 12'd410,  12'd1229},
    '{12'd410,  12'd1229, 12'd2867},
    '{12'd1229, 12'd2867, 12'd410}
  };

  typedef struct packed {
    logic signed [IN_W-1:0] normal_x;
    logic signed [IN_W-1:0] normal_y;
    logic signed [IN_W-1:0] normal_z;
    logic signed [IN_W-1:0] light_a_dx;
    logic signed [IN_W-1:0] light_a_dy;
    logic signed [IN_W-1:0] light_a_dz;
    logic signed [IN_W-1:0] light_b_dx;
    logic signed [IN_W-1:0] light_b_dy;
    logic signed [IN_W-1:0] light_b_dz;
    logic signed [IN_W-1:0] light_c_dx;
    logic signed [IN_W-1:0] light_c_dy;
    logic signed [IN_W-1:0] light_c_dz;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/tpls_delay.sv
`default_nettype none

module tpls_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] d_r [N];

  always_ff @(posedge clk) begin
    d_r[0] <= din;
    for (int s = 1; s < N; s++) begin
      d_r[s] <= d_r[s-1];
    end
  end

  assign dout = d_r[N-1];

endmodule

`default_nettype wire

>>> sv/tpls_sqrt_pipe.sv
`default_nettype none

module tpls_sqrt_pipe #(
  parameter int unsigned VW = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic [VW-1:0]          in_val,
  output logic                        out_valid,
  output logic [(VW+1)/2-1:0]         out_root
);

  localparam int unsigned RW = (VW + 1) / 2;
  localparam int unsigned TW = VW + 2;

  logic [VW-1:0] rem_r    [RW];
  logic [RW-1:0] root_r   [RW];
  logic          v_r      [RW];
  logic [VW-1:0] rem_in   [RW];
  logic [RW-1:0] root_in  [RW];
  logic          v_in     [RW];
  logic [VW-1:0] rem_nxt  [RW];
  logic [RW-1:0] root_nxt [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int unsigned BI = RW - 1 - s;
    logic [TW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in[s]  = in_val;
      assign root_in[s] = '0;
      assign v_in[s]    = in_valid;
    end else begin : g_next
      assign rem_in[s]  = rem_r[s-1];
      assign root_in[s] = root_r[s-1];
      assign v_in[s]    = v_r[s-1];
    end

    always_comb begin
      trial       = (TW'(root_in[s]) << (BI + 1)) | (TW'(1) << (2 * BI));
      ge          = TW'(rem_in[s]) >= trial;
      rem_nxt[s]  = ge ? VW'(TW'(rem_in[s]) - trial) : rem_in[s];
      root_nxt[s] = ge ? (root_in[s] | (RW'(1) << BI)) : root_in[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];

endmodule

`default_nettype wire

>>> sv/tpls_div_pipe.sv
`default_nettype none

module tpls_div_pipe #(
  parameter int unsigned NW = 44,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 14
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               out_valid,
  output logic [QW-1:0]      quotient
);

  localparam int unsigned MW = (NW > DW) ? NW : DW;

  logic [NW-1:0] rem_r   [QW];
  logic [DW-1:0] dvs_r   [QW];
  logic [QW-1:0] q_r     [QW];
  logic          v_r     [QW];
  logic [NW-1:0] rem_in  [QW];
  logic [DW-1:0] dvs_in  [QW];
  logic [QW-1:0] q_in    [QW];
  logic          v_in    [QW];
  logic [NW-1:0] rem_nxt [QW];
  logic [QW-1:0] q_nxt   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned BI = QW - 1 - s;
    logic ge;

    if (s == 0) begin : g_first
      assign rem_in[s] = dividend;
      assign dvs_in[s] = divisor;
      assign q_in[s]   = '0;
      assign v_in[s]   = in_valid;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign dvs_in[s] = dvs_r[s-1];
      assign q_in[s]   = q_r[s-1];
      assign v_in[s]   = v_r[s-1];
    end

    always_comb begin
      ge         = (MW'(rem_in[s]) >> BI) >= MW'(dvs_in[s]);
      rem_nxt[s] = ge ? (rem_in[s] - (NW'(dvs_in[s]) << BI)) : rem_in[s];
      q_nxt[s]   = ge ? (q_in[s] | (QW'(1) << BI)) : q_in[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt[s];
      dvs_r[s] <= dvs_in[s];
      q_r[s]   <= q_nxt[s];
    end
  end

  assign out_valid = v_r[QW-1];
  assign quotient  = q_r[QW-1];

endmodule

`default_nettype wire

>>> sv/tpls_light_lane.sv
`default_nettype none

module tpls_light_lane #(
  parameter int unsigned FRAC_BITS = tpls_pkg::FRAC_BITS_DEF,
  parameter int unsigned LIGHT     = 0
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic        [tpls_pkg::LEN2_W-1:0]  len2,
  input  wire logic signed [tpls_pkg::DOT_W-1:0]   dot,
  input  wire logic        [tpls_pkg::ROOT_W-1:0]  nrm_len,
  output logic                                     out_valid,
  output logic signed [tpls_pkg::PC_W+2*FRAC_BITS-tpls_pkg::OUT_FRAC:0] term [tpls_pkg::NUM_CH]
);

  localparam int unsigned L2W  = tpls_pkg::LEN2_W;
  localparam int unsigned MGW  = tpls_pkg::MAG_W;
  localparam int unsigned RTW  = tpls_pkg::ROOT_W;
  localparam int unsigned CNW  = MGW + tpls_pkg::OUT_FRAC;
  localparam int unsigned CQW  = tpls_pkg::CM_QW;
  localparam int unsigned CMW  = tpls_pkg::CM_W;
  localparam int unsigned PCW  = tpls_pkg::PC_W;
  localparam int unsigned SHF  = 2 * FRAC_BITS - tpls_pkg::OUT_FRAC;
  localparam int unsigned NW   = PCW + SHF;
  localparam int unsigned TW   = NW + 1;
  localparam int unsigned NCH  = tpls_pkg::NUM_CH;

  logic           neg0;
  logic [MGW-1:0] mag0;
  logic           sq_valid;
  logic [RTW-1:0] lq;
  logic [MGW-1:0] mag_d;
  logic           neg_d;
  logic [L2W-1:0] len2_d;

  always_comb begin
    neg0 = dot[tpls_pkg::DOT_W-1];
    mag0 = neg0 ? MGW'(-dot) : MGW'(dot);
  end

  tpls_sqrt_pipe #(.VW(L2W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_val    (len2),
    .out_valid (sq_valid),
    .out_root  (lq)
  );

  tpls_delay #(.W(L2W + 1 + MGW), .N(RTW)) u_dly_sq (
    .clk  (clk),
    .din  ({len2, neg0, mag0}),
    .dout ({len2_d, neg_d, mag_d})
  );

  logic [2*RTW-1:0] ml_r;
  logic [MGW-1:0]   mag1_r;
  logic [L2W-1:0]   len2_1_r;
  logic             neg1_r;
  logic             skip1_r;
  logic             v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    ml_r     <= (2*RTW)'(nrm_len) * (2*RTW)'(lq);
    mag1_r   <= mag_d;
    len2_1_r <= len2_d;
    neg1_r   <= neg_d;
    skip1_r  <= (nrm_len == '0) || (lq == '0);
  end

  logic           cq_valid;
  logic [CQW-1:0] cq;
  logic [L2W-1:0] len2_2;
  logic           neg2;
  logic           skip2;

  tpls_div_pipe #(.NW(CNW), .DW(2*RTW), .QW(CQW)) u_div_cos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .dividend  (CNW'(mag1_r) << tpls_pkg::OUT_FRAC),
    .divisor   (ml_r),
    .out_valid (cq_valid),
    .quotient  (cq)
  );

  tpls_delay #(.W(L2W + 2), .N(CQW)) u_dly_cos (
    .clk  (clk),
    .din  ({len2_1_r, neg1_r, skip1_r}),
    .dout ({len2_2, neg2, skip2})
  );

  logic [CMW-1:0] cm_r;
  logic [CMW-1:0] cm_nxt;
  logic [L2W-1:0] len2_3_r;
  logic           neg3_r;
  logic           skip3_r;
  logic           v2_r;

  always_comb begin
    if (skip2) begin
      cm_nxt = '0;
    end else if (cq > CQW'(tpls_pkg::OUT_ONE)) begin
      cm_nxt = CMW'(tpls_pkg::OUT_ONE);
    end else begin
      cm_nxt = CMW'(cq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= cq_valid;
    end
  end

  always_ff @(posedge clk) begin
    cm_r     <= cm_nxt;
    len2_3_r <= len2_2;
    neg3_r   <= neg2;
    skip3_r  <= skip2;
  end

  logic [PCW-1:0] pc_r [NCH];
  logic [L2W-1:0] len2_4_r;
  logic           neg4_r;
  logic           skip4_r;
  logic           v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      pc_r[c] <= PCW'(tpls_pkg::LIGHT_COLOR[LIGHT][c]) * PCW'(cm_r);
    end
    len2_4_r <= len2_3_r;
    neg4_r   <= neg3_r;
    skip4_r  <= skip3_r;
  end

  logic          tq_valid;
  logic [NW-1:0] tq [NCH];
  logic          neg5;
  logic          skip5;

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    if (c == 0) begin : g_lead
      tpls_div_pipe #(.NW(NW), .DW(L2W), .QW(NW)) u_div_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_r),
        .dividend  (NW'(pc_r[c]) << SHF),
        .divisor   (len2_4_r),
        .out_valid (tq_valid),
        .quotient  (tq[c])
      );
    end else begin : g_rest
      tpls_div_pipe #(.NW(NW), .DW(L2W), .QW(NW)) u_div_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_r),
        .dividend  (NW'(pc_r[c]) << SHF),
        .divisor   (len2_4_r),
        .out_valid (),
        .quotient  (tq[c])
      );
    end
  end

  tpls_delay #(.W(2), .N(NW)) u_dly_term (
    .clk  (clk),
    .din  ({neg4_r, skip4_r}),
    .dout ({neg5, skip5})
  );

  logic signed [TW-1:0] term_r [NCH];
  logic                 v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= tq_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      if (skip5) begin
        term_r[c] <= '0;
      end else if (neg5) begin
        term_r[c] <= -$signed(TW'(tq[c]));
      end else begin
        term_r[c] <= $signed(TW'(tq[c]));
      end
    end
  end

  assign out_valid = v4_r;
  assign term      = term_r;

endmodule

`default_nettype wire

>>> sv/three_point_light_pixel_shade_unit.sv
// Three point light pixel shader: Lambert diffuse with inverse-square falloff.
// Input channel: present one fragment on in_data and raise start; the transfer
// happens on a rising edge with start high and busy low. busy never rises, so
// one fragment may be transferred on every clock.
// Result channel: out_valid is high for exactly one cycle with the clamped
// RGB color on out_data; the receiver must take it in that cycle.
// The path is made of the 16 stage square root pipelines, the 14 stage cosine
// divider and the per-channel falloff dividers, one quotient bit per stage.
// Throughput: one fragment per clock, one result per fragment, in order.
// Reset (rst_n low at a clock edge) clears every valid bit: fragments in
// flight are dropped and no result appears until a new transfer.
`default_nettype none

module three_point_light_pixel_shade_unit #(
  parameter int unsigned FRAC_BITS = tpls_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tpls_pkg::in_item_t  in_data,
  output logic                     out_valid,
  output tpls_pkg::out_item_t      out_data
);

  localparam int unsigned SQW = tpls_pkg::SQ_W;
  localparam int unsigned L2W = tpls_pkg::LEN2_W;
  localparam int unsigned DTW = tpls_pkg::DOT_W;
  localparam int unsigned RTW = tpls_pkg::ROOT_W;
  localparam int unsigned NL  = tpls_pkg::NUM_LIGHTS;
  localparam int unsigned NCH = tpls_pkg::NUM_CH;
  localparam int unsigned OW  = tpls_pkg::OUT_W;
  localparam int unsigned TW  = tpls_pkg::PC_W + 2 * FRAC_BITS - tpls_pkg::OUT_FRAC + 1;
  localparam int unsigned SW  = TW + 2;

  assign busy = 1'b0;

  tpls_pkg::in_item_t in_r;
  logic               va_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  logic signed [15:0] nv [3];
  logic signed [15:0] lv [NL][3];

  always_comb begin
    nv[0]    = in_r.normal_x;
    nv[1]    = in_r.normal_y;
    nv[2]    = in_r.normal_z;
    lv[0][0] = in_r.light_a_dx;
    lv[0][1] = in_r.light_a_dy;
    lv[0][2] = in_r.light_a_dz;
    lv[1][0] = in_r.light_b_dx;
    lv[1][1] = in_r.light_b_dy;
    lv[1][2] = in_r.light_b_dz;
    lv[2][0] = in_r.light_c_dx;
    lv[2][1] = in_r.light_c_dy;
    lv[2][2] = in_r.light_c_dz;
  end

  logic signed [31:0] nsq_full [3];
  logic signed [31:0] lsq_full [NL][3];
  logic signed [31:0] dp_nxt   [NL][3];
  logic [SQW-1:0]     nsq_r    [3];
  logic [SQW-1:0]     lsq_r    [NL][3];
  logic signed [31:0] dp_r     [NL][3];
  logic               vb_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsq_full[i] = nv[i] * nv[i];
      for (int k = 0; k < NL; k++) begin
        lsq_full[k][i] = lv[k][i] * lv[k][i];
        dp_nxt[k][i]   = nv[i] * lv[k][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nsq_r[i] <= nsq_full[i][SQW-1:0];
      for (int k = 0; k < NL; k++) begin
        lsq_r[k][i] <= lsq_full[k][i][SQW-1:0];
        dp_r[k][i]  <= dp_nxt[k][i];
      end
    end
  end

  logic [L2W-1:0]        nn_r;
  logic [L2W-1:0]        ll_r [NL];
  logic signed [DTW-1:0] d_r  [NL];
  logic                  vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    nn_r <= L2W'(nsq_r[0]) + L2W'(nsq_r[1]) + L2W'(nsq_r[2]);
    for (int k = 0; k < NL; k++) begin
      ll_r[k] <= L2W'(lsq_r[k][0]) + L2W'(lsq_r[k][1]) + L2W'(lsq_r[k][2]);
      d_r[k]  <= DTW'(dp_r[k][0]) + DTW'(dp_r[k][1]) + DTW'(dp_r[k][2]);
    end
  end

  logic [RTW-1:0] ln;

  tpls_sqrt_pipe #(.VW(L2W)) u_sqrt_nrm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vc_r),
    .in_val    (nn_r),
    .out_valid (),
    .out_root  (ln)
  );

  logic                 lane_valid [NL];
  logic signed [TW-1:0] lane_term  [NL][NCH];

  for (genvar k = 0; k < NL; k++) begin : g_light
    tpls_light_lane #(.FRAC_BITS(FRAC_BITS), .LIGHT(k)) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vc_r),
      .len2      (ll_r[k]),
      .dot       (d_r[k]),
      .nrm_len   (ln),
      .out_valid (lane_valid[k]),
      .term      (lane_term[k])
    );
  end

  logic signed [SW-1:0] sum_r [NCH];
  logic                 vs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else begin
      vs_r <= lane_valid[0] & lane_valid[1] & lane_valid[2];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      sum_r[c] <= SW'(lane_term[0][c]) + SW'(lane_term[1][c]) + SW'(lane_term[2][c]);
    end
  end

  logic [OW-1:0]       ch_nxt [NCH];
  tpls_pkg::out_item_t out_nxt;
  tpls_pkg::out_item_t out_r;
  logic                out_valid_r;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (sum_r[c] < $signed(SW'(0))) begin
        ch_nxt[c] = '0;
      end else if (sum_r[c] > $signed(SW'(tpls_pkg::OUT_ONE))) begin
        ch_nxt[c] = OW'(tpls_pkg::OUT_ONE);
      end else begin
        ch_nxt[c] = OW'(sum_r[c]);
      end
    end
    out_nxt.red_out   = ch_nxt[0];
    out_nxt.green_out = ch_nxt[1];
    out_nxt.blue_out  = ch_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpls_pkg::*;

  localparam int LATENCY   = 52 + 2 * FRAC_BITS_DEF;
  localparam int WDOG_MAX  = 20 * LATENCY + 2000;
  localparam int N_PHASE   = 425;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  out_item_t color_q[$];
  int        mismatch_cnt;
  int        idle_cycles;
  int        sender_idle_pct;
  bit        timed_out;

  three_point_light_pixel_shade_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_item_t shade_pixel(in_item_t px);
    longint          nv[3];
    longint          lv[3];
    longint          acc[3];
    longint unsigned nn, ll, ln, lq, mag, cm, q;
    longint          d;
    bit              neg;
    out_item_t       res;
    nv[0] = px.normal_x;
    nv[1] = px.normal_y;
    nv[2] = px.normal_z;
    acc = '{0, 0, 0};
    nn = nv[0] * nv[0] + nv[1] * nv[1] + nv[2] * nv[2];
    if (nn != 0) begin
      ln = int_sqrt(nn);
      for (int k = 0; k < 3; k++) begin
        case (k)
          0: begin
            lv[0] = px.light_a_dx; lv[1] = px.light_a_dy; lv[2] = px.light_a_dz;
          end
          1: begin
            lv[0] = px.light_b_dx; lv[1] = px.light_b_dy; lv[2] = px.light_b_dz;
          end
          default: begin
            lv[0] = px.light_c_dx; lv[1] = px.light_c_dy; lv[2] = px.light_c_dz;
          end
        endcase
        ll = lv[0] * lv[0] + lv[1] * lv[1] + lv[2] * lv[2];
        d = nv[0] * lv[0] + nv[1] * lv[1] + nv[2] * lv[2];
        if (ll == 0) continue;
        lq = int_sqrt(ll);
        neg = d < 0;
        mag = neg ? -d : d;
        cm = (mag << OUT_FRAC) / (ln * lq);
        if (cm > OUT_ONE) cm = OUT_ONE;
        if (cm == 0) continue;
        for (int c = 0; c < 3; c++) begin
          q = ((longint'(LIGHT_COLOR[k][c]) * cm) << (2 * FRAC_BITS_DEF)) / (ll << OUT_FRAC);
          acc[c] += neg ? -longint'(q) : longint'(q);
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (acc[c] < 0) acc[c] = 0;
      if (acc[c] > OUT_ONE) acc[c] = OUT_ONE;
    end
    res.red_out   = acc[0][OUT_W-1:0];
    res.green_out = acc[1][OUT_W-1:0];
    res.blue_out  = acc[2][OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (color_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = color_q.pop_front();
        if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out ||
            out_data.blue_out !== want.blue_out) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red_out, want.green_out, want.blue_out,
                     out_data.red_out, out_data.green_out, out_data.blue_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (idle_cycles >= WDOG_MAX) begin
        timed_out = 1'b1;
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // hold start until the transfer, randomly idle beforehand
  task automatic send_fragment(in_item_t px);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    color_q.push_back(shade_pixel(px));
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'($urandom_range(32'h0FFF, 0)) - 16'd2048;
      2: return 16'($urandom_range(15, 0)) - 16'd8;
      default: return ($urandom_range(1, 0) != 0) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic in_item_t rand_fragment();
    in_item_t px;
    int       mode;
    logic [15:0] f[12];
    for (int i = 0; i < 12; i++) begin
      mode = $urandom_range(9, 0);
      if (mode < 5) f[i] = rand_comp(1);
      else if (mode < 8) f[i] = rand_comp(0);
      else if (mode < 9) f[i] = rand_comp(2);
      else f[i] = rand_comp(3);
    end
    if ($urandom_range(19, 0) == 0) f[0:2] = '{16'd0, 16'd0, 16'd0};
    if ($urandom_range(9, 0) == 0) begin
      mode = 3 + 3 * $urandom_range(2, 0);
      f[mode] = 0; f[mode + 1] = 0; f[mode + 2] = 0;
    end
    px = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
    return px;
  endfunction

  task automatic test_directed();
    in_item_t px;
    sender_idle_pct = 0;
    px = '0;
    send_fragment(px);
    px.normal_z = 16'sd4096; px.light_a_dz = 16'sd4096;
    px.light_b_dz = -16'sd4096; px.light_c_dx = 16'sd4096;
    send_fragment(px);
    px.light_a_dz = 16'sd1; px.light_b_dz = 16'sd2; px.light_c_dz = 16'sd3;
    send_fragment(px);
    px = {12{16'h7FFF}};
    send_fragment(px);
    px = {12{16'h8000}};
    send_fragment(px);
    px = {{3{16'h7FFF}}, {9{16'h8000}}};
    send_fragment(px);
    px = {{3{16'sd1}}, {3{16'sd1}}, {3{-16'sd1}}, 16'sd1, 16'sd0, 16'sd0};
    send_fragment(px);
    px = '0; px.normal_x = 16'sd3; px.normal_y = 16'sd4;
    px.light_a_dx = 16'sd3; px.light_a_dy = 16'sd4;
    px.light_b_dx = 16'sd300; px.light_b_dy = 16'sd400;
    px.light_c_dx = -16'sd4; px.light_c_dy = 16'sd3;
    send_fragment(px);
    px = '0; px.normal_x = 16'sd2; px.normal_y = 16'sd2; px.normal_z = 16'sd1;
    px.light_a_dx = 16'sd2; px.light_a_dy = 16'sd2; px.light_a_dz = 16'sd1;
    px.light_b_dx = 16'sd1; px.light_b_dy = 16'sd1; px.light_b_dz = 16'sd1;
    px.light_c_dx = 16'sd512;
    send_fragment(px);
    px = {{3{16'sd0}}, {9{16'sd100}}};
    send_fragment(px);
    px = {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
          16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA};
    send_fragment(px);
    px = ~px;
    send_fragment(px);
    release_start();
  endtask

  task automatic test_random(int pct);
    sender_idle_pct = pct;
    for (int i = 0; i < N_PHASE; i++) send_fragment(rand_fragment());
    release_start();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    mismatch_cnt = 0;
    idle_cycles = 0;
    sender_idle_pct = 0;
    timed_out = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(0);
    test_random(54);
    test_random(14);
    test_random(0);
    while (color_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_cnt == 0 && color_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/tpls_pkg.sv
sv/tpls_delay.sv
sv/tpls_sqrt_pipe.sv
sv/tpls_div_pipe.sv
sv/tpls_light_lane.sv
sv/three_point_light_pixel_shade_unit.sv
verif/tb.sv
